[rtl/tcc_pkg.sv]
package tcc_pkg;

    // Byte codes that carry meaning in a meter telegram.
    localparam logic [7:0] BYTE_SLASH = 8'h2F;
    localparam logic [7:0] BYTE_BANG  = 8'h21;
    localparam logic [7:0] BYTE_LF    = 8'h0A;

    // Reflected CRC-16 polynomial, start value zero, no final XOR.
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    // At most this many hex digits are taken after the '!' of a CRC line.
    localparam logic [2:0]  HEX_MAX_DIGITS = 3'd4;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;

    // Per-line parser state.
    typedef struct packed {
        logic       at_line_start;
        logic       in_crc_line;
        crc_t       hex_value;
        logic [2:0] hex_digits_seen;
        logic       hex_stopped;
    } line_state_t;

    localparam line_state_t LINE_STATE_RESET = '{
        at_line_start:   1'b1,
        in_crc_line:     1'b0,
        hex_value:       16'h0000,
        hex_digits_seen: 3'd0,
        hex_stopped:     1'b0
    };

endpackage

[rtl/tcc_in_if.sv]
interface tcc_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/tcc_out_if.sv]
interface tcc_out_if;
    logic               valid;
    logic               ready;
    logic               line_is_crc;
    logic               crc_match;
    logic [15:0]        computed_crc;
    logic [15:0]        received_crc;

    modport source (output valid, output line_is_crc, output crc_match,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input line_is_crc, input crc_match,
                    input computed_crc, input received_crc, output ready);
endinterface

[rtl/tcc_crc_fold.sv]
module tcc_crc_fold
(
    input  tcc_pkg::crc_t  crc_in,
    input  tcc_pkg::byte_t data,
    output tcc_pkg::crc_t  crc_out
);

    tcc_pkg::crc_t seed;
    tcc_pkg::crc_t acc;

    // A start-of-telegram byte restarts the CRC before it is folded in.
    assign seed = (data == tcc_pkg::BYTE_SLASH) ? tcc_pkg::CRC_INIT : crc_in;

    always_comb
    begin
        acc = seed ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ tcc_pkg::CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
    end

    assign crc_out = acc;

endmodule

[rtl/tcc_line_parser.sv]
module tcc_line_parser
(
    input  tcc_pkg::byte_t       data,
    input  tcc_pkg::line_state_t cur,
    output tcc_pkg::line_state_t nxt
);

    // Returns {is_hex, digit value}; upper and lower case letters both count.
    function automatic logic [4:0] hex_decode(input tcc_pkg::byte_t b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    logic [4:0] dec;

    assign dec = hex_decode(data);

    always_comb
    begin
        nxt = cur;
        if (cur.at_line_start)
        begin
            nxt.in_crc_line     = (data == tcc_pkg::BYTE_BANG);
            nxt.hex_value       = 16'h0000;
            nxt.hex_digits_seen = 3'd0;
            nxt.hex_stopped     = 1'b0;
            nxt.at_line_start   = 1'b0;
        end
        else if (cur.in_crc_line && !cur.hex_stopped
                 && cur.hex_digits_seen < tcc_pkg::HEX_MAX_DIGITS)
        begin
            if (!dec[4])
            begin
                nxt.hex_stopped = 1'b1;
            end
            else
            begin
                nxt.hex_value       = {cur.hex_value[11:0], dec[3:0]};
                nxt.hex_digits_seen = cur.hex_digits_seen + 3'd1;
            end
        end
        // A line feed closes the line; the next byte opens a new one.
        if (data == tcc_pkg::BYTE_LF)
        begin
            nxt.at_line_start = 1'b1;
        end
    end

endmodule

[rtl/telegram_crc_checker.sv]
// Flow: a byte accepted into the input register is processed as it moves on from there; a line feed
// loads its result into the result register as it moves on, and its result is offered from that register.
// Throughput: one item per cycle while no line feed is held; the CRC fold is eight XOR steps flattened
// into the single logic stage between the input register and the result register.
// Reset (rst_n low, asynchronous): CRCs are zero, the parser waits for the start of a line,
// and both the input register and the result register are empty.
module telegram_crc_checker
(
    input  logic          clk,
    input  logic          rst_n,
    tcc_in_if.sink        rx,
    tcc_out_if.source     result
);

    // Input register. It holds one received byte until the state update takes it.
    // A line feed can only move on when the result register is free or being
    // emptied in the same cycle; every other byte moves on at once.
    tcc_pkg::byte_t       byte_reg;
    logic                 byte_vld_reg;
    logic                 byte_vld_next;

    // Telegram state.
    tcc_pkg::crc_t        crc_reg;
    tcc_pkg::crc_t        crc_next;
    tcc_pkg::crc_t        latch_reg;
    tcc_pkg::crc_t        latch_next;
    tcc_pkg::line_state_t line_reg;
    tcc_pkg::line_state_t line_next;

    // Result register.
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 is_crc_reg;
    logic                 match_reg;
    tcc_pkg::crc_t        comp_reg;
    tcc_pkg::crc_t        rcv_reg;
    tcc_pkg::crc_t        rcv_next;

    logic                 is_lf;
    logic                 out_free;
    logic                 advance;
    logic                 emit;

    assign is_lf    = (byte_reg == tcc_pkg::BYTE_LF);
    assign out_free = !out_vld_reg || result.ready;
    assign advance  = byte_vld_reg && (!is_lf || out_free);
    assign emit     = advance && is_lf;

    assign rx.ready = !byte_vld_reg || advance;

    always_comb
    begin
        byte_vld_next = rx.ready ? rx.valid : byte_vld_reg;
    end

    tcc_crc_fold u_crc_fold
    (
        .crc_in  (crc_reg),
        .data    (byte_reg),
        .crc_out (crc_next)
    );

    tcc_line_parser u_line_parser
    (
        .data (byte_reg),
        .cur  (line_reg),
        .nxt  (line_next)
    );

    // The '!' closing a telegram latches the CRC with itself folded in.
    assign latch_next = (byte_reg == tcc_pkg::BYTE_BANG) ? crc_next : latch_reg;

    // The received value is reported only on a CRC line.
    assign rcv_next = line_next.in_crc_line ? line_next.hex_value : 16'h0000;

    always_comb
    begin
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            crc_reg      <= tcc_pkg::CRC_INIT;
            latch_reg    <= tcc_pkg::CRC_INIT;
            line_reg     <= tcc_pkg::LINE_STATE_RESET;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            out_vld_reg  <= out_vld_next;
            if (advance)
            begin
                crc_reg   <= crc_next;
                latch_reg <= latch_next;
                line_reg  <= line_next;
            end
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
        if (emit)
        begin
            is_crc_reg <= line_next.in_crc_line;
            match_reg  <= line_next.in_crc_line && (rcv_next == latch_next);
            comp_reg   <= latch_next;
            rcv_reg    <= rcv_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.line_is_crc  = is_crc_reg;
    assign result.crc_match    = match_reg;
    assign result.computed_crc = comp_reg;
    assign result.received_crc = rcv_reg;

    // The parser never takes more than four hex digits on a line.
    a_digit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg.hex_digits_seen <= tcc_pkg::HEX_MAX_DIGITS)
        else $error("hex digit count ran past its limit");

    // A line feed that moves on always leaves a result and a fresh line behind.
    a_lf_emits: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_vld_reg && line_reg.at_line_start)
        else $error("line feed did not produce a result");

    // A match is only ever reported on a CRC line.
    a_match_crc_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && result.crc_match |-> result.line_is_crc)
        else $error("match flagged on a data line");

    // Outside CRC lines the received value reads zero.
    a_rcv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !result.line_is_crc |-> result.received_crc == 16'h0000)
        else $error("received value set on a data line");

    // A held line feed must not be lost while the result register is full.
    a_lf_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_vld_reg && is_lf && out_vld_reg && !result.ready |=> byte_vld_reg && is_lf)
        else $error("stalled line feed was dropped");

endmodule

[dv/telegram_verdict_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the telegram CRC checker, predicts the verdict of
// every line from the accepted bytes and compares it with each accepted result.
module telegram_verdict_checker
(
    input  logic clk,
    input  logic rst_n,
    tcc_in_if    rx,
    tcc_out_if   result,
    output int   mismatch_count,
    output int   verdicts_pending
);

    typedef struct {
        logic          line_is_crc;
        logic          crc_match;
        tcc_pkg::crc_t computed_crc;
        tcc_pkg::crc_t received_crc;
    } verdict_t;

    verdict_t             verdict_q[$];
    tcc_pkg::crc_t        telegram_crc;
    tcc_pkg::crc_t        crc_at_bang;
    tcc_pkg::line_state_t line_st;
    int                   mismatches = 0;

    function automatic tcc_pkg::crc_t fold_crc(tcc_pkg::crc_t crc_in, tcc_pkg::byte_t b);
        tcc_pkg::crc_t c;
        c = crc_in ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ tcc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Value of a hex digit, or -1 for any other byte.
    function automatic int hex_nibble(tcc_pkg::byte_t b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b) - 'h30;
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b) - 'h41 + 10;
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b) - 'h61 + 10;
        end
        return -1;
    endfunction

    task automatic predict_byte(tcc_pkg::byte_t b);
        int       d;
        verdict_t v;
        if (b == tcc_pkg::BYTE_SLASH)
        begin
            telegram_crc = tcc_pkg::CRC_INIT;
        end
        telegram_crc = fold_crc(telegram_crc, b);
        if (b == tcc_pkg::BYTE_BANG)
        begin
            crc_at_bang = telegram_crc;
        end

        if (line_st.at_line_start)
        begin
            line_st = tcc_pkg::LINE_STATE_RESET;
            line_st.at_line_start = 1'b0;
            line_st.in_crc_line = (b == tcc_pkg::BYTE_BANG);
        end
        else if (line_st.in_crc_line && !line_st.hex_stopped &&
                 line_st.hex_digits_seen < tcc_pkg::HEX_MAX_DIGITS)
        begin
            d = hex_nibble(b);
            if (d < 0)
            begin
                line_st.hex_stopped = 1'b1;
            end
            else
            begin
                line_st.hex_value = {line_st.hex_value[11:0], d[3:0]};
                line_st.hex_digits_seen = line_st.hex_digits_seen + 3'd1;
            end
        end

        if (b == tcc_pkg::BYTE_LF)
        begin
            v.line_is_crc  = line_st.in_crc_line;
            v.received_crc = line_st.in_crc_line ? line_st.hex_value : 16'h0000;
            v.computed_crc = crc_at_bang;
            v.crc_match    = line_st.in_crc_line && (v.received_crc == crc_at_bang);
            verdict_q.push_back(v);
            line_st.at_line_start = 1'b1;
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        verdict_t v;
        if (!rst_n)
        begin
            telegram_crc = tcc_pkg::CRC_INIT;
            crc_at_bang  = tcc_pkg::CRC_INIT;
            line_st      = tcc_pkg::LINE_STATE_RESET;
            verdict_q.delete();
        end
        else
        begin
            // Results are checked before the byte of the same edge is predicted, so a
            // result can never be matched against an item that arrives with it.
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result: expected none, actual %b %b %h %h",
                             $time, result.line_is_crc, result.crc_match,
                             result.computed_crc, result.received_crc);
                    mismatches++;
                end
                else
                begin
                    v = verdict_q.pop_front();
                    check_field("line_is_crc", v.line_is_crc, result.line_is_crc);
                    check_field("crc_match", v.crc_match, result.crc_match);
                    check_field("computed_crc", v.computed_crc, result.computed_crc);
                    check_field("received_crc", v.received_crc, result.received_crc);
                end
            end
            if (rx.valid && rx.ready)
            begin
                predict_byte(rx.rx_byte);
            end
        end
        mismatch_count   <= mismatches;
        verdicts_pending <= verdict_q.size();
    end

endmodule

[dv/telegram_crc_checker_test.sv]
`timescale 1ns / 1ps

// Top of the testbench. It only makes stimulus and gives the verdict; the
// prediction and the comparison live in telegram_verdict_checker.
module telegram_crc_checker_test;

    localparam tcc_pkg::byte_t BYTE_CR         = 8'h0D;
    localparam int             HOLD_OFF_CYCLES = 200;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   verdicts_pending;
    int   bytes_sent;

    // Random idling on either side, and the request for one long stall of the receiver.
    bit sender_idles;
    bit receiver_idles;
    bit hold_off_req;

    tcc_in_if  rx_ch ();
    tcc_out_if result_ch ();

    telegram_crc_checker i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (result_ch)
    );

    telegram_verdict_checker i_verdicts
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx               (rx_ch),
        .result           (result_ch),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog. It leaves a wide margin over the slowest correct run while still
    // catching a hung handshake.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver side. It idles in short random bursts while receiver_idles is set, and
    // once on request it holds ready low for a long stretch, counted here in cycles,
    // so that results pile up inside the block and its input stalls.
    initial
    begin
        result_ch.ready = 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_off_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offers one byte and returns at the edge where it is taken. Valid stays high
    // when the next byte follows at once, so it is never lowered and raised in the
    // same step; an idle burst, when one is drawn, comes before the byte.
    task automatic send_byte(tcc_pkg::byte_t b);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (rx_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(tcc_pkg::byte_t'(s[i]));
        end
    endtask

    // Lowers valid and waits until every line verdict has come back. The first edge
    // lets the checker's count catch up with the byte taken at the previous edge.
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic tcc_pkg::byte_t hex_char(logic [3:0] nibble, bit upper);
        if (nibble < 4'd10)
        begin
            return tcc_pkg::byte_t'(8'h30 + nibble);
        end
        return tcc_pkg::byte_t'((upper ? 8'h41 : 8'h61) + nibble - 4'd10);
    endfunction

    // Printable data byte that neither clears nor latches the CRC.
    function automatic tcc_pkg::byte_t data_char();
        tcc_pkg::byte_t c;
        do
        begin
            c = tcc_pkg::byte_t'($urandom_range(32, 126));
        end
        while (c == tcc_pkg::BYTE_SLASH || c == tcc_pkg::BYTE_BANG);
        return c;
    endfunction

    // CRC of a telegram from its '/' through its '!', used to write the CRC line that
    // a meter would send.
    function automatic tcc_pkg::crc_t telegram_crc_of(tcc_pkg::byte_t q[$]);
        tcc_pkg::crc_t c;
        c = tcc_pkg::CRC_INIT;
        foreach (q[i])
        begin
            c = c ^ {8'h00, q[i]};
            repeat (8)
            begin
                c = c[0] ? ((c >> 1) ^ tcc_pkg::CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    // A well-formed telegram with random content. Half of those with a CRC line end in a
    // correct one; the rest carry a flipped bit, a short or overlong digit string, trailing
    // garbage or a random value, and some have no CRC line at all.
    task automatic send_telegram();
        tcc_pkg::byte_t tg[$];
        int             n_lines;
        int             len;
        int             mode;
        int             ndig;
        tcc_pkg::crc_t  value;
        tg.push_back(tcc_pkg::BYTE_SLASH);
        len = $urandom_range(3, 10);
        repeat (len) tg.push_back(data_char());
        tg.push_back(BYTE_CR);
        tg.push_back(tcc_pkg::BYTE_LF);
        n_lines = $urandom_range(1, 4);
        repeat (n_lines)
        begin
            len = $urandom_range(0, 14);
            repeat (len) tg.push_back(data_char());
            if ($urandom_range(0, 1) == 1)
            begin
                tg.push_back(BYTE_CR);
            end
            tg.push_back(tcc_pkg::BYTE_LF);
        end

        if ($urandom_range(0, 9) != 0)
        begin
            tg.push_back(tcc_pkg::BYTE_BANG);
            value = telegram_crc_of(tg);
            ndig  = 4;
            mode  = $urandom_range(0, 9);
            case (mode)
                5: ndig = $urandom_range(0, 3);
                6: value = value ^ (16'h0001 << $urandom_range(0, 15));
                9: value = tcc_pkg::crc_t'($urandom_range(0, 65535));
                default: ;
            endcase
            for (int i = ndig - 1; i >= 0; i--)
            begin
                tg.push_back(hex_char(value[4 * i +: 4], $urandom_range(0, 1) == 1));
            end
            if (mode == 7)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    tg.push_back(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1));
                end
            end
            if (mode == 8)
            begin
                tg.push_back(data_char());
            end
            if ($urandom_range(0, 1) == 1)
            begin
                tg.push_back(BYTE_CR);
            end
            tg.push_back(tcc_pkg::BYTE_LF);
        end

        foreach (tg[i])
        begin
            send_byte(tg[i]);
        end
    endtask

    // Raw bytes over the full range, with the meaningful codes made more frequent.
    task automatic send_noise();
        int n;
        int pick;
        n = $urandom_range(1, 24);
        repeat (n)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: send_byte(tcc_pkg::BYTE_LF);
                1: send_byte(tcc_pkg::BYTE_BANG);
                2: send_byte(tcc_pkg::BYTE_SLASH);
                default: send_byte(tcc_pkg::byte_t'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic send_telegram_or_noise();
        if ($urandom_range(0, 4) != 0)
        begin
            send_telegram();
        end
        else
        begin
            send_noise();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_off_req   = 1'b0;
        bytes_sent     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: an empty line, the byte extremes, a '!' in mid line after a
        // '/', a CRC line without digits, one with more than four digits in mixed case,
        // and CRC lines whose digits are cut short by bytes next to the hex ranges.
        send_byte(tcc_pkg::BYTE_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(tcc_pkg::BYTE_LF);
        send_text("/X!\n");
        send_text("!\n");
        send_text("!aBcDe\n");
        send_text("!12/\n");
        send_text("!9:\n");
        send_text("!fG\n");

        while (bytes_sent < 500)
        begin
            send_telegram_or_noise();
        end

        // The receiver stalls for a long stretch while short lines keep coming, so the
        // block fills up and holds off its input. Then the sender pauses until every
        // verdict is back.
        hold_off_req = 1'b1;
        repeat (50)
        begin
            case ($urandom_range(0, 2))
                0: send_byte(tcc_pkg::BYTE_LF);
                1:
                begin
                    send_byte(tcc_pkg::BYTE_BANG);
                    send_byte(tcc_pkg::BYTE_LF);
                end
                default:
                begin
                    send_byte(tcc_pkg::BYTE_BANG);
                    send_byte(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1));
                    send_byte(tcc_pkg::BYTE_LF);
                end
            endcase
        end
        wait_drained();

        while (bytes_sent < 950)
        begin
            send_telegram_or_noise();
        end

        // Last part at full rate on both sides.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        while (bytes_sent < 1180)
        begin
            send_telegram_or_noise();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tcc_pkg.sv
rtl/tcc_in_if.sv
rtl/tcc_out_if.sv
rtl/tcc_crc_fold.sv
rtl/tcc_line_parser.sv
rtl/telegram_crc_checker.sv
dv/telegram_verdict_checker.sv
dv/telegram_crc_checker_test.sv
